>>> src/ipacl_pkg.sv
// Shared constants for the IPv4 prefix ACL trie core.
package ipacl_pkg;

   // Default sizes
   localparam int NODE_SLOTS_DEF = 4096;
   localparam int RULE_SLOTS_DEF = 65536;
   localparam int ADDR_BITS_DEF  = 32;

   // Operation codes carried in the func field
   localparam logic [1:0] FUNC_CLEAR = 2'd0;
   localparam logic [1:0] FUNC_ADD   = 2'd1;
   localparam logic [1:0] FUNC_CHECK = 2'd2;

   // Stream widths
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 8;

endpackage

>>> src/ipacl_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module ipacl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/ip_prefix_acl_trie_core.sv
// Top level of the IPv4 prefix ACL trie: control sequencer around one node RAM.
//
// Usage
//   req_* : one item per operation. func selects clear table, add rule or
//           check address. An item is taken while the core is idle.
//   rsp_* : exactly one result item per request: verdict, matched, table_full.
//   Clear and unused codes go straight to the finish state and its result register.
//   Add and check take one node RAM read per trie level, so up to
//   ADDR_BITS+1 levels. An add that allocates fresh nodes writes one node
//   per cycle instead. A new item is taken only after the last one has left
//   the finish state; the serial RAM walk (data of one level gives the
//   address of the next) rules out any overlap.
//   Reset: one cycle after reset is spent writing an empty root node; the
//   core then accepts items. nodes_used returns to 1, rule_order to 0.
//   Stall: the result sits in an output register. A new request is taken
//   while it waits; the next result waits in the finish state until the
//   output register is free, and nothing is lost.
module ip_prefix_acl_trie_core #(
   parameter int NODE_SLOTS = ipacl_pkg::NODE_SLOTS_DEF,
   parameter int RULE_SLOTS = ipacl_pkg::RULE_SLOTS_DEF,
   parameter int ADDR_BITS  = ipacl_pkg::ADDR_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // func[1:0], address[33:2], prefix_len[39:34], permit[40], zero pad
   input  logic [ipacl_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // verdict[0], matched[1], table_full[2], zero pad
   output logic [ipacl_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam int NW = $clog2(NODE_SLOTS);       // node index
   localparam int UW = $clog2(NODE_SLOTS + 1);   // nodes used count
   localparam int OW = $clog2(RULE_SLOTS + 1);   // rule order number
   localparam int DW = $clog2(ADDR_BITS + 1);    // trie depth
   localparam int EW = 2 * NW + 2 + OW;          // node entry
   // entry layout: link0, link1, valid, permit, order
   localparam int VLD_BIT = 2 * NW;
   localparam int PMT_BIT = 2 * NW + 1;
   localparam int ORD_LSB = 2 * NW + 2;

   localparam logic [2:0] S_INIT  = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_WALK  = 3'd2;
   localparam logic [2:0] S_FRESH = 3'd3;
   localparam logic [2:0] S_FIN   = 3'd4;

   // request fields
   logic [1:0]  req_func;
   logic [31:0] req_address;
   logic [5:0]  req_prefix_len;
   logic        req_permit;
   assign req_func       = req_tdata[1:0];
   assign req_address    = req_tdata[33:2];
   assign req_prefix_len = req_tdata[39:34];
   assign req_permit     = req_tdata[40];

   logic [2:0]           state_ff, state_in;
   logic [NW-1:0]        cur_ff, cur_in;
   logic [DW-1:0]        depth_ff, depth_in;
   logic [ADDR_BITS-1:0] addr_ff, addr_in;
   logic [UW-1:0]        nodes_ff, nodes_in;
   logic [OW-1:0]        order_ff, order_in;
   logic                 found_ff, found_in;
   logic                 allow_ff, allow_in;
   logic [OW-1:0]        best_ff, best_in;
   logic [2:0]           res_ff, res_in;      // {table_full, matched, verdict}
   logic [1:0]           func_ff, func_in;
   logic [DW-1:0]        plen_ff, plen_in;
   logic                 permit_ff, permit_in;
   logic [OW-1:0]        my_order_ff, my_order_in;
   logic                 rsp_valid_ff;
   logic [2:0]           rsp_data_ff;

   logic                 wr_en, rd_en;
   logic [NW-1:0]        wr_addr, rd_addr;
   logic [EW-1:0]        wr_data, rd_data;

   // fields of the node just read
   logic [NW-1:0] link0, link1, next_node, alloc_node;
   logic          n_valid, n_permit, cur_bit, out_free, hit, is_full;
   logic [OW-1:0] n_order;

   assign link0    = rd_data[NW-1:0];
   assign link1    = rd_data[2*NW-1:NW];
   assign n_valid  = rd_data[VLD_BIT];
   assign n_permit = rd_data[PMT_BIT];
   assign n_order  = rd_data[EW-1:ORD_LSB];
   assign cur_bit  = addr_ff[ADDR_BITS-1];
   assign next_node = cur_bit ? link1 : link0;
   assign alloc_node = nodes_ff[NW-1:0];
   assign is_full  = (nodes_ff >= UW'(NODE_SLOTS));
   assign hit      = n_valid && (!found_ff || (n_order < best_ff));
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign req_tready = (state_ff == S_IDLE);

   ipacl_ram #(
      .WIDTH (EW),
      .DEPTH (NODE_SLOTS),
      .AW    (NW)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in    = state_ff;
      cur_in      = cur_ff;
      depth_in    = depth_ff;
      addr_in     = addr_ff;
      nodes_in    = nodes_ff;
      order_in    = order_ff;
      found_in    = found_ff;
      allow_in    = allow_ff;
      best_in     = best_ff;
      res_in      = res_ff;
      func_in     = func_ff;
      plen_in     = plen_ff;
      permit_in   = permit_ff;
      my_order_in = my_order_ff;
      wr_en       = 1'b0;
      wr_addr     = '0;
      wr_data     = '0;
      rd_en       = 1'b0;
      rd_addr     = '0;

      case (state_ff)
         S_INIT: begin
            // empty root
            wr_en    = 1'b1;
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               func_in   = req_func;
               addr_in   = req_address[ADDR_BITS-1:0];
               plen_in   = (req_prefix_len > 6'(ADDR_BITS)) ? DW'(ADDR_BITS)
                                                          : req_prefix_len[DW-1:0];
               permit_in = req_permit;
               cur_in    = '0;
               depth_in  = '0;
               found_in  = 1'b0;
               allow_in  = 1'b1;
               best_in   = '0;
               res_in    = '0;
               state_in  = S_FIN;
               case (req_func)
                  ipacl_pkg::FUNC_CLEAR: begin
                     wr_en    = 1'b1;
                     nodes_in = UW'(1);
                     order_in = '0;
                  end
                  ipacl_pkg::FUNC_ADD: begin
                     if (order_ff >= OW'(RULE_SLOTS)) begin
                        res_in = 3'b100;
                     end else begin
                        my_order_in = order_ff;
                        order_in    = order_ff + OW'(1);
                        rd_en       = 1'b1;
                        state_in    = S_WALK;
                     end
                  end
                  ipacl_pkg::FUNC_CHECK: begin
                     rd_en    = 1'b1;
                     state_in = S_WALK;
                  end
                  default: begin
                     res_in = '0;
                  end
               endcase
            end
         end
         S_WALK: begin
            if (func_ff == ipacl_pkg::FUNC_CHECK) begin
               if (hit) begin
                  found_in = 1'b1;
                  best_in  = n_order;
                  allow_in = n_permit;
               end
               if (depth_ff == DW'(ADDR_BITS) || next_node == '0) begin
                  res_in   = {1'b0, hit | found_ff, hit ? n_permit : allow_ff};
                  state_in = S_FIN;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = next_node;
                  cur_in   = next_node;
                  depth_in = depth_ff + DW'(1);
                  addr_in  = addr_ff << 1;
               end
            end else if (depth_ff == plen_ff) begin
               // end node: first rule wins
               if (!n_valid) begin
                  wr_en   = 1'b1;
                  wr_addr = cur_ff;
                  wr_data = rd_data;
                  wr_data[VLD_BIT] = 1'b1;
                  wr_data[PMT_BIT] = permit_ff;
                  wr_data[EW-1:ORD_LSB] = my_order_ff;
               end
               res_in   = 3'b000;
               state_in = S_FIN;
            end else if (next_node != '0) begin
               rd_en    = 1'b1;
               rd_addr  = next_node;
               cur_in   = next_node;
               depth_in = depth_ff + DW'(1);
               addr_in  = addr_ff << 1;
            end else if (n_valid) begin
               // shadowed by a shorter rule
               res_in   = 3'b000;
               state_in = S_FIN;
            end else if (is_full) begin
               res_in   = 3'b100;
               state_in = S_FIN;
            end else begin
               wr_en   = 1'b1;
               wr_addr = cur_ff;
               wr_data = rd_data;
               if (cur_bit) begin
                  wr_data[2*NW-1:NW] = alloc_node;
               end else begin
                  wr_data[NW-1:0] = alloc_node;
               end
               cur_in   = alloc_node;
               nodes_in = nodes_ff + UW'(1);
               depth_in = depth_ff + DW'(1);
               addr_in  = addr_ff << 1;
               state_in = S_FRESH;
            end
         end
         S_FRESH: begin
            // freshly allocated node: contents known, written once
            wr_en   = 1'b1;
            wr_addr = cur_ff;
            wr_data = '0;
            if (depth_ff == plen_ff) begin
               wr_data[VLD_BIT] = 1'b1;
               wr_data[PMT_BIT] = permit_ff;
               wr_data[EW-1:ORD_LSB] = my_order_ff;
               res_in   = 3'b000;
               state_in = S_FIN;
            end else if (is_full) begin
               res_in   = 3'b100;
               state_in = S_FIN;
            end else begin
               if (cur_bit) begin
                  wr_data[2*NW-1:NW] = alloc_node;
               end else begin
                  wr_data[NW-1:0] = alloc_node;
               end
               cur_in   = alloc_node;
               nodes_in = nodes_ff + UW'(1);
               depth_in = depth_ff + DW'(1);
               addr_in  = addr_ff << 1;
            end
         end
         S_FIN: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         nodes_ff     <= UW'(1);
         order_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         nodes_ff <= nodes_in;
         order_ff <= order_in;
         if (state_ff == S_FIN && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_in_reg: begin
         cur_ff      <= cur_in;
         depth_ff    <= depth_in;
         addr_ff     <= addr_in;
         found_ff    <= found_in;
         allow_ff    <= allow_in;
         best_ff     <= best_in;
         res_ff      <= res_in;
         func_ff     <= func_in;
         plen_ff     <= plen_in;
         permit_ff   <= permit_in;
         my_order_ff <= my_order_in;
         if (state_ff == S_FIN && out_free) begin
            rsp_data_ff <= res_ff;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(ipacl_pkg::RSP_DATA_W - 3)'(0), rsp_data_ff};

endmodule

>>> src/ipacl_checker.sv
// Port-level checks for the ACL trie core, bound to the top level.
module ipacl_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   // a waiting result must not change
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // a dropped add reports neither a verdict nor a match
   a_full_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2] |-> !rsp_tdata[1] && !rsp_tdata[0])
      else $error("table_full together with check fields");

   // bits above the three result fields stay zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:3] == 5'd0)
      else $error("result padding not zero");

   // right after reset, in the root init state: no request taken, no result shown
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("activity right after reset");

endmodule

bind ip_prefix_acl_trie_core ipacl_checker u_ipacl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
